// ===== hdl/palette_index_packer_macros.svh =====
// ----------------------------------------------------------------------------
// Palette index packer assertion macros
// Shared concurrent assertion shorthands, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PALETTE_INDEX_PACKER_MACROS_SVH
`define PALETTE_INDEX_PACKER_MACROS_SVH

// Assert a property on every rising edge of aclk outside of reset.
`define PIP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Assert that an expression is never true outside of reset.
`define PIP_NEVER(label, expr, msg) \
    `PIP_ASSERT(label, !(expr), msg)

`endif

// ===== hdl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// Palette index packer package
// Types and constants shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package pip_pkg;

    // Widths of the fixed payload fields.
    localparam int COLOR_W = 16;
    localparam int BYTE_W  = 8;

    // Color reported for a palette entry that was never taken.
    localparam logic [COLOR_W-1:0] UNUSED_COLOR = 16'hFFFF;

    // Result kinds carried on m_tuser.
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

    // Controller states.
    typedef enum logic {
        ST_PIXEL,
        ST_DUMP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // take the pixel beat on the input
        logic dump_load;  // load the next palette entry into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid;  // output register holds a beat
        logic frame_end;  // frame end flag of the pixel beat on offer
        logic dump_last;  // dump counter sits on the last entry of the mode
    } status_t;

endpackage

// ===== hdl/pip_ctrl.sv =====
// ----------------------------------------------------------------------------
// Palette index packer controller
// Decides when pixel beats are taken and steps the palette dump at frame end.
// ----------------------------------------------------------------------------
`include "palette_index_packer_macros.svh"

module pip_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             m_tready,
    input  pip_pkg::status_t status,
    output pip_pkg::cmd_t    cmd
);

    pip_pkg::state_t state_reg;
    pip_pkg::state_t state_next;
    logic            out_free;

    // The output register can take a new beat when empty or being drained.
    assign out_free = !status.out_valid || m_tready;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pip_pkg::ST_PIXEL;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state: a frame end pixel starts the dump, the last entry ends it.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pip_pkg::ST_PIXEL: begin
                if (cmd.accept && status.frame_end) begin
                    state_next = pip_pkg::ST_DUMP;
                end
            end
            pip_pkg::ST_DUMP: begin
                if (cmd.dump_load && status.dump_last) begin
                    state_next = pip_pkg::ST_PIXEL;
                end
            end
            default: state_next = pip_pkg::ST_PIXEL;
        endcase
    end

    // Outputs: handshake and datapath commands.
    always_comb begin
        s_tready      = 1'b0;
        cmd.accept    = 1'b0;
        cmd.dump_load = 1'b0;
        unique case (state_reg)
            pip_pkg::ST_PIXEL: begin
                s_tready   = out_free;
                cmd.accept = out_free && s_tvalid;
            end
            pip_pkg::ST_DUMP: begin
                cmd.dump_load = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // No pixel may enter while the palette is being dumped.
    `PIP_NEVER(a_no_accept_in_dump, (state_reg == pip_pkg::ST_DUMP) && s_tready,
        "pixel accepted during palette dump")

    // A frame end pixel always leads into the dump.
    `PIP_ASSERT(a_frame_end_dumps, cmd.accept && status.frame_end |=>
        state_reg == pip_pkg::ST_DUMP, "frame end did not start the dump")

    // The last dumped entry returns the controller to pixel intake.
    `PIP_ASSERT(a_dump_ends, cmd.dump_load && status.dump_last |=>
        state_reg == pip_pkg::ST_PIXEL, "dump did not end after the last entry")

endmodule

// ===== hdl/pip_datapath.sv =====
// ----------------------------------------------------------------------------
// Palette index packer datapath
// Palette lookup and insert, index packing, overflow flag and output register.
// ----------------------------------------------------------------------------
`include "palette_index_packer_macros.svh"

module pip_datapath #(
    parameter int MAX_INDEX_BITS = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,
    input  logic [pip_pkg::COLOR_W-1:0]  in_color,
    input  logic                         in_row_end,
    input  logic                         in_frame_end,
    input  logic                         m_tready,
    input  pip_pkg::cmd_t                cmd,
    output pip_pkg::status_t             status,
    output logic                         out_valid,
    output logic                         out_kind,
    output logic [pip_pkg::COLOR_W-1:0]  out_value,
    output logic                         out_ovf,
    output logic                         out_last
);

    localparam int DEPTH         = 1 << MAX_INDEX_BITS;
    localparam int IDX_W         = MAX_INDEX_BITS;
    localparam int PER_BYTE_WIDE = pip_pkg::BYTE_W / MAX_INDEX_BITS;

    // Palette storage: colors without reset, used bits cleared by reset.
    logic [pip_pkg::COLOR_W-1:0] entry_color_reg [DEPTH];
    logic [DEPTH-1:0]            entry_used_reg;
    logic [DEPTH-1:0]            entry_used_next;

    logic                        index_mode_reg;
    logic [pip_pkg::BYTE_W-1:0]  pack_byte_reg;
    logic [pip_pkg::BYTE_W-1:0]  pack_byte_next;
    logic [2:0]                  pack_slot_reg;
    logic [2:0]                  pack_slot_next;
    logic                        overflow_reg;
    logic                        overflow_next;
    logic [IDX_W-1:0]            dump_cnt_reg;
    logic [IDX_W-1:0]            dump_cnt_next;

    logic                        out_valid_reg;
    logic                        out_kind_reg;
    logic [pip_pkg::COLOR_W-1:0] out_value_reg;
    logic                        out_ovf_reg;
    logic                        out_last_reg;

    logic [DEPTH-1:0]            active;
    logic                        hit;
    logic [IDX_W-1:0]            hit_idx;
    logic                        have_free;
    logic [IDX_W-1:0]            free_idx;
    logic [IDX_W-1:0]            pix_idx;
    logic                        insert;
    logic                        miss_full;
    logic [2:0]                  bits_sel;
    logic [5:0]                  bit_pos;
    logic [pip_pkg::BYTE_W-1:0]  idx_shifted;
    logic [pip_pkg::BYTE_W-1:0]  byte_filled;
    logic [3:0]                  per_byte;
    logic                        emit;
    logic [IDX_W-1:0]            last_entry;
    logic                        dump_clear;
    logic [pip_pkg::COLOR_W-1:0] dump_color;

    // Entries searched in the current mode: the low four, or all of them.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            active[i] = index_mode_reg || (i < 4);
        end
    end

    // Parallel compare with lowest-index priority for a hit and a free slot.
    always_comb begin
        hit       = 1'b0;
        hit_idx   = '0;
        have_free = 1'b0;
        free_idx  = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (active[i] && entry_used_reg[i] && (entry_color_reg[i] == in_color)) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (active[i] && !entry_used_reg[i]) begin
                have_free = 1'b1;
                free_idx  = IDX_W'(i);
            end
        end
    end

    // Index of this pixel; a miss with a full palette maps to entry zero.
    assign insert    = cmd.accept && !hit && have_free;
    assign miss_full = !hit && !have_free;
    assign pix_idx   = hit ? hit_idx : (have_free ? free_idx : '0);

    // Packing: index bits above bit 7 fall off the shift.
    assign bits_sel    = index_mode_reg ? 3'(MAX_INDEX_BITS) : 3'd2;
    assign bit_pos     = 6'(pack_slot_reg) * 6'(bits_sel);
    assign idx_shifted = pip_pkg::BYTE_W'(pix_idx) << bit_pos;
    assign byte_filled = pack_byte_reg | idx_shifted;
    assign per_byte    = index_mode_reg ? 4'(PER_BYTE_WIDE) : 4'd4;
    assign emit        = ((4'(pack_slot_reg) + 4'd1) >= per_byte) || in_row_end
                         || in_frame_end;

    // Dump sequencing over the entries of the current mode.
    assign last_entry = index_mode_reg ? {IDX_W{1'b1}} : IDX_W'(3);
    assign dump_clear = cmd.dump_load && (dump_cnt_reg == last_entry);
    assign dump_color = entry_used_reg[dump_cnt_reg] ? entry_color_reg[dump_cnt_reg]
                                                     : pip_pkg::UNUSED_COLOR;

    // Next values of the packing, flag, used bits and dump counter.
    always_comb begin
        pack_byte_next  = pack_byte_reg;
        pack_slot_next  = pack_slot_reg;
        overflow_next   = overflow_reg;
        entry_used_next = entry_used_reg;
        dump_cnt_next   = dump_cnt_reg;
        if (cmd.accept) begin
            overflow_next = overflow_reg || miss_full;
            if (insert) begin
                entry_used_next[free_idx] = 1'b1;
            end
            if (emit) begin
                pack_byte_next = '0;
                pack_slot_next = '0;
            end else begin
                pack_byte_next = byte_filled;
                pack_slot_next = pack_slot_reg + 3'd1;
            end
        end
        if (cmd.dump_load) begin
            if (dump_clear) begin
                dump_cnt_next   = '0;
                entry_used_next = '0;
                overflow_next   = 1'b0;
            end else begin
                dump_cnt_next = dump_cnt_reg + IDX_W'(1);
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_mode_reg <= 1'b1;
            pack_byte_reg  <= '0;
            pack_slot_reg  <= '0;
            overflow_reg   <= 1'b0;
            entry_used_reg <= '0;
            dump_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                index_mode_reg <= cfg_wr_data;
            end
            pack_byte_reg  <= pack_byte_next;
            pack_slot_reg  <= pack_slot_next;
            overflow_reg   <= overflow_next;
            entry_used_reg <= entry_used_next;
            dump_cnt_reg   <= dump_cnt_next;
            if ((cmd.accept && emit) || cmd.dump_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Palette color write for a newly taken slot.
    always_ff @(posedge aclk) begin
        if (insert) begin
            entry_color_reg[free_idx] <= in_color;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (cmd.accept && emit) begin
            out_kind_reg  <= pip_pkg::KIND_BYTE;
            out_value_reg <= pip_pkg::COLOR_W'(byte_filled);
            out_ovf_reg   <= overflow_reg || miss_full;
            out_last_reg  <= !in_frame_end;
        end else if (cmd.dump_load) begin
            out_kind_reg  <= pip_pkg::KIND_ENTRY;
            out_value_reg <= dump_color;
            out_ovf_reg   <= overflow_reg;
            out_last_reg  <= dump_clear;
        end
    end

    // Status fields, in package order: out_valid, frame_end, dump_last.
    assign status = {out_valid_reg, in_frame_end, (dump_cnt_reg == last_entry)};

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_value = out_value_reg;
    assign out_ovf   = out_ovf_reg;
    assign out_last  = out_last_reg;

    // The frame-end clear leaves an empty palette and no overflow.
    `PIP_ASSERT(a_clear_empties, dump_clear |=> (entry_used_reg == '0) && !overflow_reg,
        "palette not cleared after dump")

endmodule

// ===== hdl/palette_index_packer.sv =====
// ----------------------------------------------------------------------------
// Palette index packer
// Builds a first-fit color palette and packs pixel indices LSB-first into bytes.
// ----------------------------------------------------------------------------
// A pixel that closes a byte shows its byte beat in the cycle after it is taken.
// Throughput: one pixel per cycle while m_tready is high and no dump runs; lookup is a
// combinational parallel compare over the palette entries of the current mode.
// Frame end adds 4 or 2^MAX_INDEX_BITS palette beats (no intake), one per m_tready cycle.
// Reset (aresetn low, synchronous) empties the palette, clears the packing and the
// overflow flag, and sets index_mode to the wide mode.
module palette_index_packer #(
    parameter int MAX_INDEX_BITS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // index_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // [15:0] pixel_color
    input  logic        s_tlast,       // row_end
    input  logic        s_tuser,       // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // [15:0] item_value, [16] overflow_seen, [23:17] zero
    output logic        m_tlast,       // last_of_run
    output logic        m_tuser        // item_kind
);

    pip_pkg::cmd_t               cmd;
    pip_pkg::status_t            status;
    logic [pip_pkg::COLOR_W-1:0] out_value;
    logic                        out_ovf;

    // Sequencing of pixel intake and palette dump.
    pip_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Palette, packing and output register.
    pip_datapath #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_color     (s_tdata),
        .in_row_end   (s_tlast),
        .in_frame_end (s_tuser),
        .m_tready     (m_tready),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (m_tvalid),
        .out_kind     (m_tuser),
        .out_value    (out_value),
        .out_ovf      (out_ovf),
        .out_last     (m_tlast)
    );

    // Result beat packing.
    assign m_tdata = {7'd0, out_ovf, out_value};

endmodule
